/* design/pfp_pkg.sv */
// ----------------------------------------------------------------------------
// pfp_pkg: shared types and constants of the PLL frequency planner
// Holds widths, frequency limits, status and register codes, and the tag
// that travels with each item through the divider chains.
// ----------------------------------------------------------------------------
package pfp_pkg;

    // Field widths
    localparam int VCO_W  = 23;                 // VCO frequency in kHz, up to 4.4 GHz
    localparam int PFD_W  = 18;
    localparam int MOD_W  = 12;
    localparam int INT_W  = 16;
    localparam int FRAC_W = 12;
    localparam int DEXP_W = 3;
    localparam int CFG_W  = 18;                 // widest configuration register
    localparam int PROD_W = PFD_W + MOD_W;      // remainder times modulus

    // Frequency limits in kHz
    localparam int unsigned F_MIN_KHZ = 137500;
    localparam int unsigned F_MAX_KHZ = 4400000;
    localparam int          DEXP_MAX  = 5;

    // Reset values of the configuration registers
    localparam logic [PFD_W-1:0] PFD_RESET = PFD_W'(10000);
    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(4095);
    localparam logic [INT_W-1:0] INT_MAX   = '1;

    // Input register, prep stage, both divider chains, multiply, output register
    localparam int LATENCY = 4 + INT_W + FRAC_W;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_OVF   = 2'd2
    } t_status;

    typedef enum logic {
        CFG_PFD = 1'b0,
        CFG_MOD = 1'b1
    } t_cfg_idx;

    // Per-item control carried alongside the divider data
    typedef struct packed {
        logic               valid;
        t_status            status;
        logic [DEXP_W-1:0]  dexp;
        logic [INT_W-1:0]   iw;
    } t_tag;

endpackage

/* design/pfp_div_cell.sv */
// ----------------------------------------------------------------------------
// pfp_div_cell: one restoring division step
// Brings down the next dividend bit into the partial remainder, subtracts the
// divisor when it fits and shifts the quotient bit into the dividend word.
// ----------------------------------------------------------------------------
module pfp_div_cell
    import pfp_pkg::*;
#(
    parameter int NUM_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [PFD_W-1:0]  i_div,
    input  t_tag              i_tag,
    input  logic [PFD_W-1:0]  i_rem,
    input  logic [NUM_W-1:0]  i_num,
    output t_tag              o_tag,
    output logic [PFD_W-1:0]  o_rem,
    output logic [NUM_W-1:0]  o_num
);

    logic [PFD_W:0]   trial;
    logic             fits;
    logic [PFD_W-1:0] n_rem;
    logic [NUM_W-1:0] n_num;
    t_tag             r_tag;
    logic [PFD_W-1:0] r_rem;
    logic [NUM_W-1:0] r_num;

    // Trial subtract of the divisor from the extended remainder
    always_comb begin
        trial = {i_rem, i_num[NUM_W-1]};
        fits  = trial >= {1'b0, i_div};
        n_rem = fits ? PFD_W'(trial - {1'b0, i_div}) : trial[PFD_W-1:0];
        n_num = {i_num[NUM_W-2:0], fits};
    end

    // Hand control to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    // Hand data to the next cell
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_num <= n_num;
    end

    assign o_tag = r_tag;
    assign o_rem = r_rem;
    assign o_num = r_num;

endmodule

/* design/pfp_div_chain.sv */
// ----------------------------------------------------------------------------
// pfp_div_chain: row of division cells
// Divides {rem, num} by the divisor one quotient bit per cell; after NUM_W
// cells the num word holds the quotient and rem the remainder.
// ----------------------------------------------------------------------------
module pfp_div_chain
    import pfp_pkg::*;
#(
    parameter int NUM_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [PFD_W-1:0]  i_div,
    input  t_tag              i_tag,
    input  logic [PFD_W-1:0]  i_rem,
    input  logic [NUM_W-1:0]  i_num,
    output t_tag              o_tag,
    output logic [PFD_W-1:0]  o_rem,
    output logic [NUM_W-1:0]  o_quot
);

    t_tag             tag_link [NUM_W+1];
    logic [PFD_W-1:0] rem_link [NUM_W+1];
    logic [NUM_W-1:0] num_link [NUM_W+1];

    assign tag_link[0] = i_tag;
    assign rem_link[0] = i_rem;
    assign num_link[0] = i_num;

    // One cell per quotient bit, most significant first
    for (genvar g = 0; g < NUM_W; g++) begin : g_cell
        pfp_div_cell #(
            .NUM_W (NUM_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_div   (i_div),
            .i_tag   (tag_link[g]),
            .i_rem   (rem_link[g]),
            .i_num   (num_link[g]),
            .o_tag   (tag_link[g+1]),
            .o_rem   (rem_link[g+1]),
            .o_num   (num_link[g+1])
        );
    end

    assign o_tag  = tag_link[NUM_W];
    assign o_rem  = rem_link[NUM_W];
    assign o_quot = num_link[NUM_W];

endmodule

/* design/pll_frac_n_frequency_plan.sv */
// ----------------------------------------------------------------------------
// pll_frac_n_frequency_plan: fractional-N PLL divider settings from a frequency
// Range check, output divider choice, integer and fraction words.
// ----------------------------------------------------------------------------
// Pulse i_start with a frequency in kHz on any clock; o_busy is always low, so
// one item is taken every cycle. Each result appears on o_valid for a single
// cycle exactly LATENCY (32) cycles after its item was taken, in order, and
// must be captured then. The latency is set by the two restoring divider
// chains, one cell per quotient bit: 16 cells for the integer word and 12 for
// the fraction word, plus input, prep, multiply and output registers.
// pfd_khz and modulus may be rewritten only when no item is in flight.
module pll_frac_n_frequency_plan
    import pfp_pkg::*;
#(
    parameter int FREQ_WIDTH = 23
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [FREQ_WIDTH-1:0] i_freq_khz,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output logic                  o_valid,
    output logic [1:0]            o_status,
    output logic [DEXP_W-1:0]     o_div_exponent,
    output logic [INT_W-1:0]      o_int_word,
    output logic [FRAC_W-1:0]     o_frac_word
);

    logic [PFD_W-1:0]      r_pfd;
    logic [MOD_W-1:0]      r_mod;
    logic                  r_a_vld;
    logic [FREQ_WIDTH-1:0] r_a_freq;
    t_tag                  n_b_tag;
    logic [VCO_W-1:0]      n_b_vco;
    t_tag                  r_b_tag;
    logic [VCO_W-1:0]      r_b_vco;
    t_tag                  c1_in_tag;
    t_tag                  c1_tag;
    logic [PFD_W-1:0]      c1_rem;
    logic [INT_W-1:0]      c1_quot;
    t_tag                  n_m_tag;
    t_tag                  r_m_tag;
    logic [PROD_W-1:0]     r_m_prod;
    t_tag                  c2_tag;
    logic [PFD_W-1:0]      c2_rem;
    logic [FRAC_W-1:0]     c2_quot;
    logic                  r_valid;
    t_status               r_status;
    logic [DEXP_W-1:0]     r_dexp;
    logic [INT_W-1:0]      r_iw;
    logic [FRAC_W-1:0]     r_fw;
    logic                  in_range;
    logic [VCO_W-1:0]      freq_lo;
    logic [DEXP_W-1:0]     dexp;
    logic                  ovf;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pfd <= PFD_RESET;
            r_mod <= MOD_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_PFD: r_pfd <= i_cfg_data[PFD_W-1:0];
                CFG_MOD: r_mod <= i_cfg_data[MOD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_freq <= i_freq_khz;
    end

    // Check range, pick the largest divider exponent, scale to the VCO
    always_comb begin
        in_range = (r_a_freq >= FREQ_WIDTH'(F_MIN_KHZ)) &&
                   (r_a_freq <= FREQ_WIDTH'(F_MAX_KHZ));
        freq_lo  = r_a_freq[VCO_W-1:0];
        dexp     = '0;
        for (int d = 1; d <= DEXP_MAX; d++) begin
            if (freq_lo <= VCO_W'(F_MAX_KHZ >> d)) begin
                dexp = DEXP_W'(d);
            end
        end
        if (!in_range) begin
            dexp = '0;
        end
        n_b_tag.valid  = r_a_vld;
        n_b_tag.status = in_range ? ST_OK : ST_RANGE;
        n_b_tag.dexp   = dexp;
        n_b_tag.iw     = '0;
        n_b_vco        = freq_lo << dexp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_tag <= '0;
        end else begin
            r_b_tag <= n_b_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_vco <= n_b_vco;
    end

    // Flag an integer word above 16 bits; a zero PFD lands here too
    always_comb begin
        ovf       = {(PFD_W+INT_W-VCO_W)'(0), r_b_vco} >= {r_pfd, INT_W'(0)};
        c1_in_tag = r_b_tag;
        if (r_b_tag.status == ST_OK && ovf) begin
            c1_in_tag.status = ST_OVF;
        end
    end

    // Integer word: VCO frequency over PFD frequency
    pfp_div_chain #(
        .NUM_W (INT_W)
    ) u_int_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_div   (r_pfd),
        .i_tag   (c1_in_tag),
        .i_rem   (PFD_W'(r_b_vco[VCO_W-1:INT_W])),
        .i_num   (r_b_vco[INT_W-1:0]),
        .o_tag   (c1_tag),
        .o_rem   (c1_rem),
        .o_quot  (c1_quot)
    );

    // Attach the integer word to the item
    always_comb begin
        n_m_tag    = c1_tag;
        n_m_tag.iw = c1_quot;
    end

    // Scale the remainder by the modulus
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tag <= '0;
        end else begin
            r_m_tag <= n_m_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_prod <= PROD_W'(c1_rem) * PROD_W'(r_mod);
    end

    // Fraction word: scaled remainder over PFD frequency
    pfp_div_chain #(
        .NUM_W (FRAC_W)
    ) u_frac_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_div   (r_pfd),
        .i_tag   (r_m_tag),
        .i_rem   (r_m_prod[PROD_W-1:FRAC_W]),
        .i_num   (r_m_prod[FRAC_W-1:0]),
        .o_tag   (c2_tag),
        .o_rem   (c2_rem),
        .o_quot  (c2_quot)
    );

    // Final remainder is not needed
    logic unused_rem;
    assign unused_rem = ^c2_rem;

    // Format the result by status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_status <= ST_OK;
            r_dexp   <= '0;
            r_iw     <= '0;
            r_fw     <= '0;
        end else begin
            r_valid  <= c2_tag.valid;
            r_status <= c2_tag.status;
            case (c2_tag.status)
                ST_OK: begin
                    r_dexp <= c2_tag.dexp;
                    r_iw   <= c2_tag.iw;
                    r_fw   <= c2_quot;
                end
                ST_OVF: begin
                    r_dexp <= c2_tag.dexp;
                    r_iw   <= INT_MAX;
                    r_fw   <= '0;
                end
                default: begin
                    r_dexp <= '0;
                    r_iw   <= '0;
                    r_fw   <= '0;
                end
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_div_exponent = r_dexp;
    assign o_int_word     = r_iw;
    assign o_frac_word    = r_fw;

endmodule

/* design/pfp_checker.sv */
// ----------------------------------------------------------------------------
// pfp_checker: port-level checks of the PLL frequency planner
// Fixed latency between item and result, result field rules per status, and the exponent bound.
// ----------------------------------------------------------------------------
module pfp_checker
    import pfp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               i_busy,
    input logic               i_valid,
    input logic [1:0]         i_status,
    input logic [DEXP_W-1:0]  i_div_exponent,
    input logic [INT_W-1:0]   i_int_word,
    input logic [FRAC_W-1:0]  i_frac_word
);

    localparam int CNT_W = $clog2(LATENCY + 1);

    logic [CNT_W-1:0] r_run;

    // Count cycles out of reset, saturate at the latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (r_run != CNT_W'(LATENCY)) begin
            r_run <= r_run + CNT_W'(1);
        end
    end

    // One result per item, a fixed number of cycles later
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run == CNT_W'(LATENCY)) |-> (i_valid == $past(i_start && !i_busy, LATENCY)))
        else $error("result strobe does not match item taken LATENCY cycles ago");

    // Out of range results carry zero fields
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status == ST_RANGE) |->
        (i_div_exponent == '0 && i_int_word == '0 && i_frac_word == '0))
        else $error("out of range result with nonzero fields");

    // Overflow saturates the integer word and clears the fraction
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status == ST_OVF) |-> (i_int_word == INT_MAX && i_frac_word == '0))
        else $error("overflow result not saturated");

    // Divider exponent stays within the output divider range
    a_dexp_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_div_exponent <= DEXP_W'(DEXP_MAX)))
        else $error("divider exponent beyond maximum");

endmodule

bind pll_frac_n_frequency_plan pfp_checker u_pfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .i_busy         (o_busy),
    .i_valid        (o_valid),
    .i_status       (o_status),
    .i_div_exponent (o_div_exponent),
    .i_int_word     (o_int_word),
    .i_frac_word    (o_frac_word)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for pll_frac_n_frequency_plan
// Drives frequency requests through a queue-fed driver, predicts the divider
// settings for each item from the current register values, and checks every
// result in order. Runs several register settings, including zero and extreme
// PFD values and degenerate moduli, under changing sender idle patterns.
// ----------------------------------------------------------------------------
module tb;
    import pfp_pkg::*;

    localparam int FREQ_W      = 23;
    localparam int N_PHASES    = 12;
    localparam int N_RAND      = 145;
    localparam int STALL_LIMIT = 1000;

    typedef struct {
        logic [FREQ_W-1:0] freq;
        bit                drain;
    } t_request;

    typedef struct packed {
        t_status           status;
        logic [DEXP_W-1:0] dexp;
        logic [INT_W-1:0]  iw;
        logic [FRAC_W-1:0] fw;
    } t_plan;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic                  o_busy;
    logic [FREQ_W-1:0]     i_freq_khz = '0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_addr = CFG_PFD;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  o_valid;
    logic [1:0]            o_status;
    logic [DEXP_W-1:0]     o_div_exponent;
    logic [INT_W-1:0]      o_int_word;
    logic [FRAC_W-1:0]     o_frac_word;

    // Register copies seen by the predictor
    logic [PFD_W-1:0] pfd_cfg = PFD_RESET;
    logic [MOD_W-1:0] mod_cfg = MOD_RESET;

    t_request requests_pending[$];
    t_plan    plans_due[$];

    int  gap_pct = 0;
    bit  took = 1'b0;
    int  n_taken = 0;
    int  n_checked = 0;
    int  n_ok = 0;
    int  n_range = 0;
    int  n_ovf = 0;
    int  mismatch_cnt = 0;
    int  stall_cycles = 0;

    pll_frac_n_frequency_plan #(.FREQ_WIDTH(FREQ_W)) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_freq_khz     (i_freq_khz),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_div_exponent (o_div_exponent),
        .o_int_word     (o_int_word),
        .o_frac_word    (o_frac_word)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Compute the divider settings for one request
    function automatic t_plan plan_of(input logic [FREQ_W-1:0] freq,
                                      input logic [PFD_W-1:0] pfd,
                                      input logic [MOD_W-1:0] modv);
        t_plan           p;
        longint unsigned f, vco, q, r;
        int unsigned     k;
        p.status = ST_OK;
        p.dexp   = '0;
        p.iw     = '0;
        p.fw     = '0;
        f = freq;
        if (f < F_MIN_KHZ || f > F_MAX_KHZ) begin
            p.status = ST_RANGE;
        end else begin
            // largest output divider that keeps the VCO at or below the top
            k = 0;
            while (k < DEXP_MAX && (f << (k + 1)) <= F_MAX_KHZ)
                k++;
            vco    = f << k;
            p.dexp = k[DEXP_W-1:0];
            if (pfd == '0) begin
                p.status = ST_OVF;
                p.iw     = INT_MAX;
            end else begin
                q = vco / pfd;
                r = vco % pfd;
                if (q > INT_MAX) begin
                    p.status = ST_OVF;
                    p.iw     = INT_MAX;
                end else begin
                    p.iw = q[INT_W-1:0];
                    p.fw = FRAC_W'((r * modv) / pfd);
                end
            end
        end
        return p;
    endfunction

    // Pick a random request: mostly valid, some full range, some at band edges
    function automatic logic [FREQ_W-1:0] random_freq();
        int unsigned edges[6] = '{137500, 275000, 550000, 1100000, 2200000, 4400000};
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return FREQ_W'($urandom_range(F_MAX_KHZ, F_MIN_KHZ));
        else if (sel < 80)
            return FREQ_W'($urandom);
        else
            return FREQ_W'(edges[$urandom_range(5)] + $urandom_range(4) - 2);
    endfunction

    // Driver: hold an item until taken, then send the next or idle
    always @(negedge i_clk) begin : drive_items
        logic              nxt_start;
        logic [FREQ_W-1:0] nxt_freq;
        t_request          req;
        nxt_start = i_start;
        nxt_freq  = i_freq_khz;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else if (!i_start || took) begin
            nxt_start = 1'b0;
            nxt_freq  = FREQ_W'($urandom);
            if (requests_pending.size() != 0
                    && !(requests_pending[0].drain && plans_due.size() != 0)
                    && $urandom_range(99) >= gap_pct) begin
                req       = requests_pending.pop_front();
                nxt_start = 1'b1;
                nxt_freq  = req.freq;
            end
        end
        i_start    <= nxt_start;
        i_freq_khz <= nxt_freq;
    end

    // Monitor: predict on each taken item, check each result against the oldest
    always @(posedge i_clk) begin : check_results
        t_plan want, got;
        if (!i_rst_n) begin
            took = 1'b0;
        end else begin
            took = i_start && !o_busy;
            if (took) begin
                want = plan_of(i_freq_khz, pfd_cfg, mod_cfg);
                plans_due.push_back(want);
                n_taken++;
                case (want.status)
                    ST_OK:    n_ok++;
                    ST_RANGE: n_range++;
                    default:  n_ovf++;
                endcase
            end
            if (o_valid) begin
                got.status = t_status'(o_status);
                got.dexp   = o_div_exponent;
                got.iw     = o_int_word;
                got.fw     = o_frac_word;
                if (plans_due.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR: unexpected result status=%0d dexp=%0d int=%0d frac=%0d",
                                 got.status, got.dexp, got.iw, got.fw);
                end else begin
                    want = plans_due.pop_front();
                    n_checked++;
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"ERROR: result %0d exp status=%0d dexp=%0d int=%0d",
                                      " frac=%0d, got status=%0d dexp=%0d int=%0d frac=%0d"},
                                     n_checked, want.status, want.dexp, want.iw, want.fw,
                                     got.status, got.dexp, got.iw, got.fw);
                    end
                end
            end
            // watchdog on cycles where nothing moves
            if (took || o_valid)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Wait until nothing is queued or in flight and i_start is low on consecutive
    // falling edges, so an item the driver launches at the first is still seen
    task automatic wait_drained();
        int quiet;
        quiet = 0;
        while (quiet < 2) begin
            @(negedge i_clk);
            if (requests_pending.size() != 0 || plans_due.size() != 0 || i_start)
                quiet = 0;
            else
                quiet++;
        end
    endtask

    // Write one register while idle and update the predictor copy
    task automatic write_cfg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_PFD)
            pfd_cfg = data[PFD_W-1:0];
        else
            mod_cfg = data[MOD_W-1:0];
        @(negedge i_clk);
    endtask

    task automatic push_request(input logic [FREQ_W-1:0] freq, input bit drain);
        t_request req;
        req.freq  = freq;
        req.drain = drain;
        requests_pending.push_back(req);
    endtask

    initial begin : stimulus
        int unsigned directed[19] = '{
            0, 137499, 137500, 137501, 275000, 275001, 550000, 550001,
            1100000, 1100001, 2200000, 2200001, 4399999, 4400000, 4400001,
            8388607, 1234567, 3141592, 4095
        };
        int unsigned pfd_tab[7] = '{10000, 1, 262143, 0, 67, 68, 25000};
        int unsigned mod_tab[7] = '{4095, 4095, 2, 4095, 1, 0, 4095};
        int          gap_tab[4] = '{0, 64, 0, 12};
        logic [CFG_W-1:0] pfd_val, mod_val;
        int ph, n;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            if (ph != 0) begin
                if (ph < 7) begin
                    pfd_val = CFG_W'(pfd_tab[ph]);
                    mod_val = CFG_W'(mod_tab[ph]);
                end else begin
                    // random settings; junk above the modulus width must be dropped
                    pfd_val = CFG_W'($urandom_range(100000, 30));
                    mod_val = {6'($urandom), 12'($urandom_range(4095, 2))};
                end
                write_cfg(CFG_PFD, pfd_val);
                write_cfg(CFG_MOD, mod_val);
                i_cfg_we <= 1'b0;
            end
            gap_pct = gap_tab[ph % 4];
            if (ph == 0) begin
                foreach (directed[i])
                    push_request(FREQ_W'(directed[i]), 1'b0);
            end
            // hold item 40, and now and then another, back in each phase until the pipe is empty
            for (n = 0; n < N_RAND; n++)
                push_request(random_freq(), n == 40 || $urandom_range(99) == 0);
        end

        wait_drained();
        repeat (LATENCY) @(posedge i_clk);

        $display("Sent %0d requests over %0d register settings: %0d planned, %0d out of range, %0d overflowed.",
                 n_taken, N_PHASES, n_ok, n_range, n_ovf);
        $display("Checked %0d results, %0d mismatches, %0d still outstanding.",
                 n_checked, mismatch_cnt, plans_due.size());
        if (mismatch_cnt == 0 && plans_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
